// ===== src/esc_pkg.sv =====
// ----------------------------------------------------------------------------
// esc_pkg
// Shared types and constants for the epoch seconds to calendar converter.
// ----------------------------------------------------------------------------
package esc_pkg;

    localparam int EPOCH_W  = 31;
    localparam int ZONE_W   = 17;
    localparam int TOTAL_W  = 32;
    localparam int DAYS_W   = 15;
    localparam int YEAR_W   = 11;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MIN_W    = 6;
    localparam int SEC_W    = 6;
    localparam int SOD_W    = 17;   // seconds of day
    localparam int SOH_W    = 12;   // seconds of hour
    localparam int DAY_LOW_W       = 7;    // 86400 = 675 << 7
    localparam int DAY_RECIP_SHIFT = 35;

    localparam logic [ZONE_W-1:0]  ZONE_RESET   = 17'd28800;
    localparam logic [TOTAL_W-1:0] SECS_PER_DAY = 32'd86400;
    localparam logic [25:0]        DAY_RECIP    = 26'd50903317; // 2^35 / 675, rounded up
    localparam logic [15:0]        HOUR_RECIP   = 16'd37283; // 2^27 / 3600, rounded up
    localparam logic [12:0]        MIN_RECIP    = 13'd4370;  // 2^18 / 60, rounded up
    localparam logic [11:0]        SECS_PER_HOUR = 12'd3600;
    localparam logic [6:0]         SECS_PER_MIN  = 7'd60;

    localparam logic [YEAR_W-1:0]  FIRST_YEAR   = 11'd1970;
    localparam logic [1:0]         FIRST_MOD4   = 2'd2;
    localparam logic [6:0]         FIRST_MOD100 = 7'd70;
    localparam logic [8:0]         FIRST_MOD400 = 9'd370;
    localparam logic [6:0]         LAST_MOD100  = 7'd99;
    localparam logic [8:0]         LAST_MOD400  = 9'd399;
    localparam logic [MONTH_W-1:0] JANUARY      = 4'd1;
    localparam logic [MONTH_W-1:0] FEBRUARY     = 4'd2;
    localparam logic [MONTH_W-1:0] DECEMBER     = 4'd12;
    localparam logic [8:0]         DAYS_COMMON  = 9'd365;
    localparam logic [8:0]         DAYS_LEAP    = 9'd366;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DAY,
        ST_DAY_REM,
        ST_HOUR,
        ST_REM,
        ST_MIN,
        ST_SEC,
        ST_YEAR,
        ST_MONTH
    } t_state;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_DAY,
        CMD_DAY_REM,
        CMD_HOUR,
        CMD_REM,
        CMD_MIN,
        CMD_SEC,
        CMD_YEAR,
        CMD_MONTH,
        CMD_PUBLISH
    } t_cmd;

    typedef struct packed {
        logic year_fits;
        logic month_fits;
        logic out_free;
    } t_status;

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (month) inside
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            FEBRUARY:                len = leap ? 5'd29 : 5'd28;
            default:                 len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// ===== src/epoch_seconds_to_calendar.sv =====
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar
// Converts seconds since the epoch (UTC) to local Gregorian date and time.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one epoch count per
//   transaction. The zone offset register (signed seconds) is written via
//   i_cfg_wr_en / i_cfg_wr_data; the user must write it only while the block
//   is idle, which the block itself does not enforce. It resets to 28800.
//   Output channel (o_out_valid / i_out_ready) delivers year, month, day,
//   hour, minute and second for each input transaction.
//   After an item is accepted, the sequencer runs two day-split steps, four
//   time-of-day steps, one year step per year past 1970 plus one that finds
//   the year, and one month step per month past January plus one that
//   publishes the result. One item is in flight at a time.
//   The result register holds a finished result while the next item is
//   accepted and worked on; if the receiver stalls, the next result waits in
//   the last step until the register is free.
//   Reset (synchronous, active low) empties the result register, returns
//   the sequencer to idle and restores the zone offset.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [esc_pkg::ZONE_W-1:0]   i_cfg_wr_data,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [esc_pkg::EPOCH_W-1:0]  i_epoch_seconds,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [esc_pkg::YEAR_W-1:0]   o_year,
    output logic [esc_pkg::MONTH_W-1:0]  o_month,
    output logic [esc_pkg::DAY_W-1:0]    o_day_of_month,
    output logic [esc_pkg::HOUR_W-1:0]   o_hour,
    output logic [esc_pkg::MIN_W-1:0]    o_minute,
    output logic [esc_pkg::SEC_W-1:0]    o_second
);

    logic [esc_pkg::ZONE_W-1:0] r_zone;
    esc_pkg::t_cmd              w_cmd;
    esc_pkg::t_status           w_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone <= esc_pkg::ZONE_RESET;
        end else if (i_cfg_wr_en) begin
            r_zone <= i_cfg_wr_data;
        end
    end

    esc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    esc_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_epoch_seconds (i_epoch_seconds),
        .i_zone          (r_zone),
        .i_out_ready     (i_out_ready),
        .o_status        (w_status),
        .o_out_valid     (o_out_valid),
        .o_year          (o_year),
        .o_month         (o_month),
        .o_day_of_month  (o_day_of_month),
        .o_hour          (o_hour),
        .o_minute        (o_minute),
        .o_second        (o_second)
    );

    // busy once a transaction is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted while previous item still in progress");

    a_month_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_month >= 4'd1 && o_month <= 4'd12 && o_day_of_month != 5'd0))
        else $error("month or day out of range");

    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_hour <= 5'd23 && o_minute <= 6'd59 && o_second <= 6'd59))
        else $error("time of day out of range");

    a_year_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_year >= 11'd1970 && o_year <= 11'd2038))
        else $error("year out of range");

endmodule

// ===== src/esc_ctrl.sv =====
// ----------------------------------------------------------------------------
// esc_ctrl
// Sequencer for the converter: day split, time of day, year and month walk.
// ----------------------------------------------------------------------------
module esc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  esc_pkg::t_status  i_status,
    output logic              o_in_ready,
    output esc_pkg::t_cmd     o_cmd
);

    esc_pkg::t_state r_state;
    esc_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= esc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            esc_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = esc_pkg::ST_DAY;
            end
            esc_pkg::ST_DAY:     n_state = esc_pkg::ST_DAY_REM;
            esc_pkg::ST_DAY_REM: n_state = esc_pkg::ST_HOUR;
            esc_pkg::ST_HOUR: n_state = esc_pkg::ST_REM;
            esc_pkg::ST_REM:  n_state = esc_pkg::ST_MIN;
            esc_pkg::ST_MIN:  n_state = esc_pkg::ST_SEC;
            esc_pkg::ST_SEC:  n_state = esc_pkg::ST_YEAR;
            esc_pkg::ST_YEAR: begin
                if (i_status.year_fits) n_state = esc_pkg::ST_MONTH;
            end
            esc_pkg::ST_MONTH: begin
                if (i_status.month_fits && i_status.out_free) n_state = esc_pkg::ST_IDLE;
            end
            default: n_state = esc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = esc_pkg::CMD_NONE;
        unique case (r_state)
            esc_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) o_cmd = esc_pkg::CMD_LOAD;
            end
            esc_pkg::ST_DAY:     o_cmd = esc_pkg::CMD_DAY;
            esc_pkg::ST_DAY_REM: o_cmd = esc_pkg::CMD_DAY_REM;
            esc_pkg::ST_HOUR: o_cmd = esc_pkg::CMD_HOUR;
            esc_pkg::ST_REM:  o_cmd = esc_pkg::CMD_REM;
            esc_pkg::ST_MIN:  o_cmd = esc_pkg::CMD_MIN;
            esc_pkg::ST_SEC:  o_cmd = esc_pkg::CMD_SEC;
            esc_pkg::ST_YEAR: begin
                if (!i_status.year_fits) o_cmd = esc_pkg::CMD_YEAR;
            end
            esc_pkg::ST_MONTH: begin
                if (!i_status.month_fits) begin
                    o_cmd = esc_pkg::CMD_MONTH;
                end else if (i_status.out_free) begin
                    o_cmd = esc_pkg::CMD_PUBLISH;
                end
            end
            default: o_cmd = esc_pkg::CMD_NONE;
        endcase
    end

endmodule

// ===== src/esc_datapath.sv =====
// ----------------------------------------------------------------------------
// esc_datapath
// Registers and arithmetic of the converter, plus the result register.
// ----------------------------------------------------------------------------
module esc_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  esc_pkg::t_cmd                 i_cmd,
    input  logic [esc_pkg::EPOCH_W-1:0]   i_epoch_seconds,
    input  logic [esc_pkg::ZONE_W-1:0]    i_zone,
    input  logic                          i_out_ready,
    output esc_pkg::t_status              o_status,
    output logic                          o_out_valid,
    output logic [esc_pkg::YEAR_W-1:0]    o_year,
    output logic [esc_pkg::MONTH_W-1:0]   o_month,
    output logic [esc_pkg::DAY_W-1:0]     o_day_of_month,
    output logic [esc_pkg::HOUR_W-1:0]    o_hour,
    output logic [esc_pkg::MIN_W-1:0]     o_minute,
    output logic [esc_pkg::SEC_W-1:0]     o_second
);

    logic [esc_pkg::TOTAL_W-1:0]  r_total;
    logic [esc_pkg::DAYS_W-1:0]   r_days;
    logic [esc_pkg::HOUR_W-1:0]   r_hour;
    logic [esc_pkg::SOH_W-1:0]    r_rem;
    logic [esc_pkg::MIN_W-1:0]    r_minute;
    logic [esc_pkg::SEC_W-1:0]    r_second;
    logic [esc_pkg::YEAR_W-1:0]   r_year;
    logic [1:0]                   r_mod4;
    logic [6:0]                   r_mod100;
    logic [8:0]                   r_mod400;
    logic [esc_pkg::MONTH_W-1:0]  r_month;
    logic                         r_out_valid;
    logic [esc_pkg::YEAR_W-1:0]   r_out_year;
    logic [esc_pkg::MONTH_W-1:0]  r_out_month;
    logic [esc_pkg::DAY_W-1:0]    r_out_day;
    logic [esc_pkg::HOUR_W-1:0]   r_out_hour;
    logic [esc_pkg::MIN_W-1:0]    r_out_minute;
    logic [esc_pkg::SEC_W-1:0]    r_out_second;

    logic [esc_pkg::ZONE_W+15:0]  w_sum;      // 33 bits, signed view
    logic [esc_pkg::TOTAL_W-esc_pkg::DAY_LOW_W-1:0] w_tdiv;
    logic [50:0]                  w_dprod;
    logic [32:0]                  w_hprod;
    logic [24:0]                  w_mprod;
    logic                         w_leap;
    logic [8:0]                   w_ylen;
    logic [esc_pkg::DAY_W-1:0]    w_mlen;

    assign w_sum = {2'b00, i_epoch_seconds} + {{16{i_zone[esc_pkg::ZONE_W-1]}}, i_zone};
    // days = (total >> 7) / 675, exact by reciprocal for a 25-bit dividend
    assign w_tdiv    = r_total[esc_pkg::TOTAL_W-1:esc_pkg::DAY_LOW_W];
    assign w_dprod   = 51'(w_tdiv) * 51'(esc_pkg::DAY_RECIP);
    assign w_hprod   = 33'(r_total[esc_pkg::SOD_W-1:0]) * 33'(esc_pkg::HOUR_RECIP);
    assign w_mprod   = 25'(r_rem) * 25'(esc_pkg::MIN_RECIP);
    assign w_leap    = ((r_mod4 == 2'd0) && (r_mod100 != 7'd0)) || (r_mod400 == 9'd0);
    assign w_ylen    = w_leap ? esc_pkg::DAYS_LEAP : esc_pkg::DAYS_COMMON;
    assign w_mlen    = esc_pkg::month_len(r_month, w_leap);

    assign o_status.year_fits  = (r_days < esc_pkg::DAYS_W'(w_ylen));
    assign o_status.month_fits = (r_days < esc_pkg::DAYS_W'(w_mlen))
                                 || (r_month == esc_pkg::DECEMBER);
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        unique case (i_cmd)
            esc_pkg::CMD_LOAD: begin
                // negative local time clamps to the epoch itself
                r_total  <= w_sum[32] ? '0 : w_sum[31:0];
                r_days   <= '0;
                r_year   <= esc_pkg::FIRST_YEAR;
                r_mod4   <= esc_pkg::FIRST_MOD4;
                r_mod100 <= esc_pkg::FIRST_MOD100;
                r_mod400 <= esc_pkg::FIRST_MOD400;
                r_month  <= esc_pkg::JANUARY;
            end
            esc_pkg::CMD_DAY: begin
                r_days <= w_dprod[esc_pkg::DAY_RECIP_SHIFT +: esc_pkg::DAYS_W];
            end
            esc_pkg::CMD_DAY_REM: begin
                // seconds within the day
                r_total <= r_total - (esc_pkg::TOTAL_W'(r_days) * esc_pkg::SECS_PER_DAY);
            end
            esc_pkg::CMD_HOUR: begin
                r_hour <= w_hprod[31:27];
            end
            esc_pkg::CMD_REM: begin
                r_rem <= esc_pkg::SOH_W'(r_total[esc_pkg::SOD_W-1:0]
                         - (17'(r_hour) * 17'(esc_pkg::SECS_PER_HOUR)));
            end
            esc_pkg::CMD_MIN: begin
                r_minute <= w_mprod[23:18];
            end
            esc_pkg::CMD_SEC: begin
                r_second <= esc_pkg::SEC_W'(r_rem
                            - (12'(r_minute) * 12'(esc_pkg::SECS_PER_MIN)));
            end
            esc_pkg::CMD_YEAR: begin
                r_days   <= r_days - esc_pkg::DAYS_W'(w_ylen);
                r_year   <= r_year + 1'b1;
                r_mod4   <= r_mod4 + 1'b1;
                r_mod100 <= (r_mod100 == esc_pkg::LAST_MOD100) ? 7'd0 : r_mod100 + 1'b1;
                r_mod400 <= (r_mod400 == esc_pkg::LAST_MOD400) ? 9'd0 : r_mod400 + 1'b1;
            end
            esc_pkg::CMD_MONTH: begin
                r_days  <= r_days - esc_pkg::DAYS_W'(w_mlen);
                r_month <= r_month + 1'b1;
            end
            esc_pkg::CMD_PUBLISH: begin
                r_out_year   <= r_year;
                r_out_month  <= r_month;
                r_out_day    <= esc_pkg::DAY_W'(r_days + 1'b1);
                r_out_hour   <= r_hour;
                r_out_minute <= r_minute;
                r_out_second <= r_second;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd == esc_pkg::CMD_PUBLISH) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_year         = r_out_year;
    assign o_month        = r_out_month;
    assign o_day_of_month = r_out_day;
    assign o_hour         = r_out_hour;
    assign o_minute       = r_out_minute;
    assign o_second       = r_out_second;

endmodule
